[hdl/cort_pkg.sv]
package cort_pkg;

  // Fixed field widths of the request, result and configuration channels
  localparam int unsigned SECTOR_W = 40;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned BLKIDX_W = 16;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned TOTAL_W  = 17;
  localparam int unsigned STAT_W   = 48;
  localparam int unsigned COPY_W   = 17;
  localparam int unsigned CFGIDX_W = 2;

  // Bitmap row: 16 blocks per memory word
  localparam int unsigned ROW_BITS = 16;
  localparam int unsigned ROW_LSB  = 4;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_COPY_DONE = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ROUTE_REJECT    = 3'd0,
    ROUTE_ORIGIN    = 3'd1,
    ROUTE_CACHE     = 3'd2,
    ROUTE_COPY      = 3'd3,
    ROUTE_WAIT      = 3'd4,
    ROUTE_COPY_ACK  = 3'd5,
    ROUTE_QUERY_OK  = 3'd6,
    ROUTE_QUERY_OOR = 3'd7
  } route_e;

  typedef enum logic [1:0] {
    CFG_SECTOR_LOG2  = 2'd0,
    CFG_LAST_SECTOR  = 2'd1,
    CFG_TOTAL_BLOCKS = 2'd2
  } cfg_idx_e;

  typedef logic [ROW_BITS-1:0] row_bits_t;
  typedef logic [ROW_LSB-1:0]  row_pos_t;

  typedef struct packed {
    row_bits_t present;
    row_bits_t in_flight;
  } map_row_t;

  typedef struct packed {
    logic             any_miss;
    row_pos_t         miss_pos;
    logic             in_flight;
    logic [ROW_LSB:0] hits;
  } scan_t;

endpackage

[hdl/cort_intf.sv]
interface cort_req_if;
  logic                                 valid;
  logic                                 ready;
  cort_pkg::op_e                        operation;
  logic [cort_pkg::SECTOR_W-1:0]        start_sector;
  logic [cort_pkg::COUNT_W-1:0]         sector_count;
  logic [cort_pkg::BLKIDX_W-1:0]        block_index;
  logic                                 copy_error;

  modport source (output valid, output operation, output start_sector, output sector_count,
                  output block_index, output copy_error, input ready);
  modport sink   (input valid, input operation, input start_sector, input sector_count,
                  input block_index, input copy_error, output ready);
endinterface

interface cort_rsp_if;
  logic                                 valid;
  logic                                 ready;
  cort_pkg::route_e                     route;
  logic [cort_pkg::BLKIDX_W-1:0]        target_block;
  logic                                 present_bit;
  logic [cort_pkg::STAT_W-1:0]          hit_total;
  logic [cort_pkg::STAT_W-1:0]          miss_total;
  logic [cort_pkg::COPY_W-1:0]          copied_total;

  modport source (output valid, output route, output target_block, output present_bit,
                  output hit_total, output miss_total, output copied_total, input ready);
  modport sink   (input valid, input route, input target_block, input present_bit,
                  input hit_total, input miss_total, input copied_total, output ready);
endinterface

interface cort_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [cort_pkg::CFGIDX_W-1:0]        index;
  logic [cort_pkg::SECTOR_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/cort_bitmap_ram.sv]
module cort_bitmap_ram #(
  parameter int unsigned ROWS   = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  cort_pkg::map_row_t  wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output cort_pkg::map_row_t  rdata_o
);
  import cort_pkg::*;

  map_row_t mem_q [ROWS];
  map_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cort_row_scan.sv]
module cort_row_scan (
  input  cort_pkg::map_row_t  row_i,
  input  cort_pkg::row_pos_t  lo_i,
  input  cort_pkg::row_pos_t  hi_i,
  output cort_pkg::scan_t     scan_o
);
  import cort_pkg::*;

  row_bits_t window;
  row_bits_t miss;
  row_pos_t  pos;
  logic      pos_in_flight;

  // window of blocks [lo, hi] in this row, then lowest block not present
  always_comb begin
    for (int i = 0; i < ROW_BITS; i++) begin
      window[i] = (row_pos_t'(i) >= lo_i) && (row_pos_t'(i) <= hi_i);
    end
    miss = window & ~row_i.present;
    pos  = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (miss[i]) begin
        pos = row_pos_t'(i);
      end
    end
  end

  assign pos_in_flight = row_i.in_flight[pos];

  always_comb begin
    scan_o.any_miss  = |miss;
    scan_o.miss_pos  = pos;
    scan_o.in_flight = pos_in_flight;
    // present blocks before the first miss are hits; a wait adds one more
    if (|miss) begin
      scan_o.hits = {1'b0, pos - lo_i} + {{ROW_LSB{1'b0}}, pos_in_flight};
    end else begin
      scan_o.hits = {1'b0, hi_i - lo_i} + {{ROW_LSB{1'b0}}, 1'b1};
    end
  end

endmodule

[hdl/copy_on_read_block_cache_tracker.sv]
// Copy-on-read block cache tracker.
// req_i carries one request per handshake: read, write, copy done or
// present-bit query. rsp_o returns exactly one result per request, in order,
// with the running hit/miss/copied totals as they stand after that request.
// cfg_i writes the log2 sectors-per-block shift (0), the last cacheable
// sector (1) and the total block count (2); it is always ready. The user
// must write it only while the tracker is idle; it does not enforce this.
// A write goes straight to its result. Copy done and query fetch the
// bitmap row first (a block outside the store or the query range goes
// straight to the result); a read finds its sector range and block span,
// then goes to origin or walks the bitmap rows (a row holds 16 blocks),
// one row fetch and one scan per row. The sequencer is back in idle on
// the edge that loads the result; one request is in work at a time. The
// walk through the bitmap memory sets the rate of reads.
// After reset the bitmap memory is swept clear, one row per cycle, over
// all ceil(NUM_BLOCKS/16) rows (4096 at the default); req_i stays not ready
// meanwhile. A finished result sits in an output register: a new request is
// accepted while it waits, and the tracker holds the next result until
// rsp_o drains.
module copy_on_read_block_cache_tracker #(
  parameter int unsigned NUM_BLOCKS          = 65536,
  parameter int unsigned MAX_REQUEST_SECTORS = 4096
) (
  input logic          clk_i,
  input logic          rst_ni,
  cort_req_if.sink     req_i,
  cort_rsp_if.source   rsp_o,
  cort_cfg_if.sink     cfg_i
);
  import cort_pkg::*;

  localparam int unsigned BLK_W  = $clog2(NUM_BLOCKS);
  localparam int unsigned ROWS   = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LBA_W  = SECTOR_W + 1;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_RANGE  = 10'b00_0000_0100,
    S_SPAN   = 10'b00_0000_1000,
    S_DECIDE = 10'b00_0001_0000,
    S_FETCH  = 10'b00_0010_0000,
    S_SCAN   = 10'b00_0100_0000,
    S_CDONE  = 10'b00_1000_0000,
    S_QUERY  = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_e;

  state_e                  state_q;
  op_e                     op_q;
  logic [SECTOR_W-1:0]     start_q;
  logic [COUNT_W-1:0]      count_q;
  logic                    err_q;
  logic [BLK_W-1:0]        cur_blk_q;
  logic [LBA_W-1:0]        last_q;
  logic [LBA_W-1:0]        first_q;
  logic [LBA_W-1:0]        lastblk_q;
  route_e                  route_q;
  logic [BLKIDX_W-1:0]     target_q;
  logic                    pbit_q;
  logic [ROW_AW-1:0]       clr_row_q;

  // persistent tracker state
  logic                    bypass_q;
  logic [STAT_W-1:0]       hit_q;
  logic [STAT_W-1:0]       miss_q;
  logic [COPY_W-1:0]       copy_q;

  // configuration
  logic [SHIFT_W-1:0]      shift_q;
  logic [SECTOR_W-1:0]     last_sector_q;
  logic [TOTAL_W-1:0]      total_q;

  // result register
  logic                    rsp_valid_q;
  route_e                  rsp_route_q;
  logic [BLKIDX_W-1:0]     rsp_target_q;
  logic                    rsp_pbit_q;
  logic [STAT_W-1:0]       rsp_hit_q;
  logic [STAT_W-1:0]       rsp_miss_q;
  logic [COPY_W-1:0]       rsp_copy_q;

  logic                    req_fire;
  logic [COUNT_W-1:0]      count_sat;
  logic [LBA_W-1:0]        shift_src;
  logic [LBA_W-1:0]        shift_res;
  logic                    blk_in_store;
  logic                    blk_in_bound;
  logic                    last_row;
  logic                    go_origin;
  row_pos_t                scan_lo;
  row_pos_t                scan_hi;
  row_pos_t                cur_pos;
  scan_t                   scan;
  logic [BLK_W-1:0]        miss_blk;
  logic                    emit_load;

  logic                    ram_we;
  logic [ROW_AW-1:0]       ram_waddr;
  logic [ROW_AW-1:0]       ram_raddr;
  map_row_t                ram_wdata;
  map_row_t                ram_rdata;
  logic                    ram_re;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // zero count reads as one sector, oversized counts saturate
  always_comb begin
    if (req_i.sector_count == '0) begin
      count_sat = COUNT_W'(1);
    end else if ({19'd0, req_i.sector_count} > 32'(MAX_REQUEST_SECTORS)) begin
      count_sat = COUNT_W'(MAX_REQUEST_SECTORS);
    end else begin
      count_sat = req_i.sector_count;
    end
  end

  assign blk_in_store = {16'd0, req_i.block_index} < 32'(NUM_BLOCKS);
  assign blk_in_bound = blk_in_store && ({1'b0, req_i.block_index} < total_q);

  // one barrel shifter: start sector in S_RANGE, last sector in S_SPAN
  assign shift_src = (state_q == S_RANGE) ? {1'b0, start_q} : last_q;
  assign shift_res = shift_src >> shift_q;

  assign go_origin = bypass_q || (last_q > {1'b0, last_sector_q})
                  || (lastblk_q >= LBA_W'(NUM_BLOCKS));

  // row walk window
  assign cur_pos  = row_pos_t'(cur_blk_q);
  assign last_row = (cur_blk_q >> ROW_LSB) == (BLK_W'(lastblk_q) >> ROW_LSB);
  assign scan_lo  = cur_pos;
  assign scan_hi  = last_row ? row_pos_t'(lastblk_q) : '1;
  assign miss_blk = (cur_blk_q & ~BLK_W'(ROW_BITS - 1)) | BLK_W'(scan.miss_pos);

  cort_row_scan u_scan (
    .row_i  (ram_rdata),
    .lo_i   (scan_lo),
    .hi_i   (scan_hi),
    .scan_o (scan)
  );

  // bitmap memory port control
  assign ram_raddr = ROW_AW'(cur_blk_q >> ROW_LSB);
  assign ram_re    = (state_q == S_FETCH);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_raddr;
    ram_wdata = ram_rdata;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_q;
        ram_wdata = '0;
      end
      S_SCAN: begin
        // first missing block not yet in flight: mark it
        if (scan.any_miss && !scan.in_flight) begin
          ram_we = 1'b1;
          ram_wdata.in_flight[scan.miss_pos] = 1'b1;
        end
      end
      S_CDONE: begin
        ram_we = 1'b1;
        if (!err_q) begin
          ram_wdata.present[cur_pos] = 1'b1;
        end
        ram_wdata.in_flight[cur_pos] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  cort_bitmap_ram #(
    .ROWS   (ROWS),
    .ADDR_W (ROW_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign emit_load = (state_q == S_EMIT) && (!rsp_valid_q || rsp_o.ready);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      op_q      <= OP_READ;
      start_q   <= '0;
      count_q   <= '0;
      err_q     <= 1'b0;
      cur_blk_q <= '0;
      last_q    <= '0;
      first_q   <= '0;
      lastblk_q <= '0;
      route_q   <= ROUTE_REJECT;
      target_q  <= '0;
      pbit_q    <= 1'b0;
      clr_row_q <= '0;
      bypass_q  <= 1'b0;
      hit_q     <= '0;
      miss_q    <= '0;
      copy_q    <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_row_q <= clr_row_q + ROW_AW'(1);
          if (clr_row_q == ROW_AW'(ROWS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            op_q      <= req_i.operation;
            start_q   <= req_i.start_sector;
            count_q   <= count_sat;
            err_q     <= req_i.copy_error;
            cur_blk_q <= BLK_W'(req_i.block_index);
            target_q  <= '0;
            pbit_q    <= 1'b0;
            unique case (req_i.operation)
              OP_READ: begin
                state_q <= S_RANGE;
              end
              OP_WRITE: begin
                route_q <= ROUTE_REJECT;
                state_q <= S_EMIT;
              end
              OP_COPY_DONE: begin
                // error trips bypass even for a block outside the store
                if (req_i.copy_error) begin
                  bypass_q <= 1'b1;
                end
                route_q <= ROUTE_COPY_ACK;
                state_q <= blk_in_store ? S_FETCH : S_EMIT;
              end
              OP_QUERY: begin
                route_q <= blk_in_bound ? ROUTE_QUERY_OK : ROUTE_QUERY_OOR;
                state_q <= blk_in_bound ? S_FETCH : S_EMIT;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RANGE: begin
          last_q  <= LBA_W'(start_q) + LBA_W'(count_q) - LBA_W'(1);
          first_q <= shift_res;
          state_q <= S_SPAN;
        end
        S_SPAN: begin
          lastblk_q <= shift_res;
          state_q   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (go_origin) begin
            // every block spanned counts as a miss
            miss_q  <= miss_q + STAT_W'(lastblk_q - first_q + LBA_W'(1));
            route_q <= ROUTE_ORIGIN;
            state_q <= S_EMIT;
          end else begin
            cur_blk_q <= BLK_W'(first_q);
            state_q   <= S_FETCH;
          end
        end
        S_FETCH: begin
          unique case (op_q)
            OP_READ:      state_q <= S_SCAN;
            OP_COPY_DONE: state_q <= S_CDONE;
            default:      state_q <= S_QUERY;
          endcase
        end
        S_SCAN: begin
          hit_q <= hit_q + STAT_W'(scan.hits);
          if (scan.any_miss) begin
            target_q <= BLKIDX_W'(miss_blk);
            if (scan.in_flight) begin
              route_q <= ROUTE_WAIT;
            end else begin
              route_q <= ROUTE_COPY;
              miss_q  <= miss_q + STAT_W'(1);
              copy_q  <= copy_q + COPY_W'(1);
            end
            state_q <= S_EMIT;
          end else if (last_row) begin
            route_q <= ROUTE_CACHE;
            state_q <= S_EMIT;
          end else begin
            cur_blk_q <= (cur_blk_q | BLK_W'(ROW_BITS - 1)) + BLK_W'(1);
            state_q   <= S_FETCH;
          end
        end
        S_CDONE: begin
          state_q <= S_EMIT;
        end
        S_QUERY: begin
          pbit_q  <= ram_rdata.present[cur_pos];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q       <= SHIFT_W'(3);
      last_sector_q <= '0;
      total_q       <= TOTAL_W'(65536);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_SECTOR_LOG2:  shift_q       <= cfg_i.data[SHIFT_W-1:0];
        CFG_LAST_SECTOR:  last_sector_q <= cfg_i.data;
        CFG_TOTAL_BLOCKS: total_q       <= cfg_i.data[TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result register: frees the sequencer while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q  <= 1'b0;
      rsp_route_q  <= ROUTE_REJECT;
      rsp_target_q <= '0;
      rsp_pbit_q   <= 1'b0;
      rsp_hit_q    <= '0;
      rsp_miss_q   <= '0;
      rsp_copy_q   <= '0;
    end else if (emit_load) begin
      rsp_valid_q  <= 1'b1;
      rsp_route_q  <= route_q;
      rsp_target_q <= target_q;
      rsp_pbit_q   <= pbit_q;
      rsp_hit_q    <= hit_q;
      rsp_miss_q   <= miss_q;
      rsp_copy_q   <= copy_q;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.route        = rsp_route_q;
  assign rsp_o.target_block = rsp_target_q;
  assign rsp_o.present_bit  = rsp_pbit_q;
  assign rsp_o.hit_total    = rsp_hit_q;
  assign rsp_o.miss_total   = rsp_miss_q;
  assign rsp_o.copied_total = rsp_copy_q;

`ifndef SYNTHESIS
  // an accepted request always moves the sequencer out of idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after a request");

  // copies are started only by the row scan
  a_copy_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_q != $past(copy_q) |-> $past(state_q) == S_SCAN)
    else $error("copy counter moved outside the row scan");

  // one row step adds at most a row's worth of hits
  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q - $past(hit_q)) <= STAT_W'(ROW_BITS))
    else $error("hit counter stepped by more than one row");

  // results are only loaded from the emit state
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result loaded outside emit");
`endif

endmodule
